### rtl/core/bpl_pkg.sv
// ----------------------------------------------------------------------------
// Bounded positional list package
// Request and status codes, cell commands and the cell control bundle.
// ----------------------------------------------------------------------------
package bpl_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;
    localparam logic [1:0] ACT_SORT   = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_BADPOS  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [2:0] CELL_HOLD    = 3'd0;
    localparam logic [2:0] CELL_INSERT  = 3'd1;
    localparam logic [2:0] CELL_DELETE  = 3'd2;
    localparam logic [2:0] CELL_COMPARE = 3'd3;
    localparam logic [2:0] CELL_SCAN    = 3'd4;
    localparam logic [2:0] CELL_SORT    = 3'd5;

    typedef struct packed {
        logic [2:0]         op;
        logic               phase;
        logic signed [31:0] value;
    } t_cell_ctl;

endpackage

### rtl/core/bpl_cell.sv
// ----------------------------------------------------------------------------
// Bounded positional list cell
// Holds one list entry and one match flag; trades data with its neighbors.
// ----------------------------------------------------------------------------
module bpl_cell
    import bpl_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int IDX      = 0,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [CW-1:0]      i_idx,
    input  logic [CW-1:0]      i_count,
    input  logic signed [31:0] i_left_data,
    input  logic signed [31:0] i_right_data,
    input  logic               i_right_match,
    output logic signed [31:0] o_data,
    output logic               o_match
);

    localparam logic [CW-1:0] MY        = CW'(IDX);
    localparam logic [CW:0]   MYP1      = (CW + 1)'(IDX + 1);
    localparam bit            HAS_LEFT  = (IDX > 0);
    localparam bit            HAS_RIGHT = (IDX < CAPACITY - 1);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               r_match;
    logic               n_match;
    logic               is_left;
    logic               pair_ok;

    always_comb begin
        n_data  = r_data;
        n_match = r_match;
        // In each sort round a cell is the lower or upper half of a pair.
        is_left = (MY[0] == i_ctl.phase);
        pair_ok = is_left ? (HAS_RIGHT && (MYP1 < {1'b0, i_count}))
                          : (HAS_LEFT && (MY < i_count));
        case (i_ctl.op)
            CELL_INSERT: begin
                if (MY == i_idx) begin
                    n_data = i_ctl.value;
                end else if (MY > i_idx) begin
                    n_data = i_left_data;
                end
            end
            CELL_DELETE: begin
                if (MY >= i_idx) begin
                    n_data = i_right_data;
                end
            end
            CELL_COMPARE: begin
                n_match = (MY < i_count) && (r_data == i_ctl.value);
            end
            CELL_SCAN: begin
                n_match = i_right_match;
            end
            CELL_SORT: begin
                if (pair_ok) begin
                    if (is_left && (r_data > i_right_data)) begin
                        n_data = i_right_data;
                    end else if (!is_left && (i_left_data > r_data)) begin
                        n_data = i_left_data;
                    end
                end
            end
            default: begin
                n_data  = r_data;
                n_match = r_match;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

### rtl/core/bounded_positional_list_top.sv
// Insert and delete: the result strobe follows the accepting edge.
// Search: compare in every cell, then the match flags shift toward cell 0,
// one position a cycle, until the result strobe.
// Sort: odd-even transposition over the cell chain.
// Reset clears the length and control; entries are defined once inserted.
// Results cannot be stalled; busy is high while a search or sort runs.
// ----------------------------------------------------------------------------
// Bounded positional list top level
// Control sequencer and result registers around a chain of list cells.
// ----------------------------------------------------------------------------
module bounded_positional_list_top
    import bpl_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic [5:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic               o_found,
    output logic [5:0]         o_found_position,
    output logic [5:0]         o_length
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = ((CW > 6) ? CW : 6) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SORT = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_step;
    logic [CW-1:0] n_step;
    logic          r_strobe;
    logic          n_strobe;
    logic [1:0]    r_status;
    logic [1:0]    n_status;
    logic          r_found;
    logic          n_found;
    logic [5:0]    r_found_pos;
    logic [5:0]    n_found_pos;

    t_cell_ctl          w_ctl;
    logic [CW-1:0]      w_idx;
    logic [VW-1:0]      pos_w;
    logic [VW-1:0]      cnt_w;
    logic               ins_bad;
    logic               del_bad;
    logic signed [31:0] w_data  [CAPACITY];
    logic               w_match [CAPACITY];

    assign pos_w   = VW'(i_position);
    assign cnt_w   = VW'(r_count);
    assign ins_bad = (pos_w == '0) || (pos_w > cnt_w + VW'(1));
    assign del_bad = (pos_w == '0) || (pos_w > cnt_w);
    // Only used once the position is known to be in range.
    assign w_idx   = CW'(pos_w - VW'(1));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_strobe    = 1'b0;
        n_status    = r_status;
        n_found     = r_found;
        n_found_pos = r_found_pos;
        w_ctl.op    = CELL_HOLD;
        w_ctl.phase = r_step[0];
        w_ctl.value = i_value;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status    = ST_DONE;
                    n_found     = 1'b0;
                    n_found_pos = '0;
                    case (i_action)
                        ACT_INSERT: begin
                            n_strobe = 1'b1;
                            if (r_count == CAP_C) begin
                                n_status = ST_FULL;
                            end else if (ins_bad) begin
                                n_status = ST_BADPOS;
                            end else begin
                                w_ctl.op = CELL_INSERT;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        ACT_DELETE: begin
                            n_strobe = 1'b1;
                            if (del_bad) begin
                                n_status = ST_BADPOS;
                            end else begin
                                w_ctl.op = CELL_DELETE;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        ACT_SEARCH: begin
                            w_ctl.op = CELL_COMPARE;
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                                n_step  = '0;
                            end
                        end
                        ACT_SORT: begin
                            if (r_count < CW'(2)) begin
                                n_strobe = 1'b1;
                            end else begin
                                n_state = S_SORT;
                                n_step  = '0;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Cell 0 holds the match flag of list position r_step + 1.
                if (w_match[0]) begin
                    n_found     = 1'b1;
                    n_found_pos = 6'(r_step + CW'(1));
                    n_strobe    = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_step + CW'(1) == r_count) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    w_ctl.op = CELL_SCAN;
                    n_step   = r_step + CW'(1);
                end
            end
            S_SORT: begin
                w_ctl.op = CELL_SORT;
                if (r_step == r_count - CW'(1)) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_step = r_step + CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_status    <= n_status;
        r_found     <= n_found;
        r_found_pos <= n_found_pos;
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [31:0] left_data;
            logic signed [31:0] right_data;
            logic               right_match;
            if (g == 0) begin : g_first
                assign left_data = i_value;
            end else begin : g_inner_l
                assign left_data = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_data  = w_data[g];
                assign right_match = 1'b0;
            end else begin : g_inner_r
                assign right_data  = w_data[g+1];
                assign right_match = w_match[g+1];
            end
            bpl_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (g),
                .CW       (CW)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_idx         (w_idx),
                .i_count       (r_count),
                .i_left_data   (left_data),
                .i_right_data  (right_data),
                .i_right_match (right_match),
                .o_data        (w_data[g]),
                .o_match       (w_match[g])
            );
        end
    endgenerate

    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_status         = r_status;
    assign o_found          = r_found;
    assign o_found_position = r_found_pos;
    assign o_length         = 6'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("list length above capacity");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_FULL)) |-> (o_length == 6'(CAPACITY)))
        else $error("full status with list not full");

    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_found) |-> ((o_found_position != 6'd0 || CAPACITY > 62)
                                   && (o_status == ST_DONE)))
        else $error("search hit without a position");

    a_edit_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_action == ACT_INSERT) || (i_action == ACT_DELETE)))
        |=> o_strobe)
        else $error("insert or delete result late");

endmodule

### tb/bpl_checker.sv
// ----------------------------------------------------------------------------
// Bounded positional list checker
// Watches the request and result ports, keeps a shadow copy of the list and
// compares every result strobe with the oldest predicted result.
// ----------------------------------------------------------------------------
module bpl_checker
    import bpl_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         i_action,
    input  logic [5:0]         i_position,
    input  logic signed [31:0] i_value,
    input  logic               o_strobe,
    input  logic [1:0]         o_status,
    input  logic               o_found,
    input  logic [5:0]         o_found_position,
    input  logic [5:0]         o_length,
    output int                 o_error_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [5:0] found_position;
        logic [5:0] length;
    } t_list_result;

    logic signed [31:0] shadow_list [CAPACITY];
    int                 shadow_length = 0;
    t_list_result       expected_results [$];
    int                 error_count = 0;

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("%0t ns bpl_checker: %s", $time, msg);
    endtask

    // Applies one request to the shadow list and returns its result.
    function automatic t_list_result apply_request(input logic [1:0] act,
                                                   input logic [5:0] pos,
                                                   input logic signed [31:0] val);
        t_list_result       res;
        int                 p;
        int                 k;
        int                 j;
        logic signed [31:0] held;
        res = '0;
        p   = int'(pos);
        case (act)
            ACT_INSERT: begin
                if (shadow_length >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (p == 0 || p > shadow_length + 1) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (k = shadow_length; k > p - 1; k--) begin
                        shadow_list[k] = shadow_list[k - 1];
                    end
                    shadow_list[p - 1] = val;
                    shadow_length++;
                end
            end
            ACT_DELETE: begin
                if (p == 0 || p > shadow_length) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (k = p - 1; k + 1 < shadow_length; k++) begin
                        shadow_list[k] = shadow_list[k + 1];
                    end
                    shadow_length--;
                end
            end
            ACT_SEARCH: begin
                for (k = 0; k < shadow_length; k++) begin
                    if (shadow_list[k] == val) begin
                        res.found          = 1'b1;
                        res.found_position = 6'(k + 1);
                        break;
                    end
                end
            end
            default: begin
                // Equal values may land in any order; no output can tell.
                for (k = 1; k < shadow_length; k++) begin
                    held = shadow_list[k];
                    j    = k;
                    while (j > 0 && shadow_list[j - 1] > held) begin
                        shadow_list[j] = shadow_list[j - 1];
                        j--;
                    end
                    shadow_list[j] = held;
                end
            end
        endcase
        res.length = 6'(shadow_length);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            shadow_length = 0;
            expected_results.delete();
        end else begin
            // The result strobe belongs to an earlier request, so it is
            // retired before the request taken at this edge is predicted.
            if (o_strobe === 1'b1) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with no request waiting, status %0d",
                                              o_status));
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    end
                    if (o_found !== want.found) begin
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  o_found, want.found));
                    end
                    if (o_found_position !== want.found_position) begin
                        report_mismatch($sformatf("found_position %0d, expected %0d",
                                                  o_found_position, want.found_position));
                    end
                    if (o_length !== want.length) begin
                        report_mismatch($sformatf("length %0d, expected %0d",
                                                  o_length, want.length));
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                expected_results.push_back(apply_request(i_action, i_position, i_value));
            end
        end
        o_pending     <= expected_results.size();
        o_error_count <= error_count;
    end

endmodule

### tb/bounded_positional_list_top_tb.sv
// ----------------------------------------------------------------------------
// Bounded positional list testbench
// Drives directed and random insert, delete, search and sort requests with
// random gaps; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module bounded_positional_list_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpl_pkg::*;

    localparam int CAPACITY       = 32;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int PHASE_ITEMS    = 60;
    localparam int LATENCY_CYCLES = 2 * CAPACITY + 8;

    logic               i_clk;
    logic               i_rst_n          = 1'b0;
    logic               start            = 1'b0;
    logic               busy;
    logic [1:0]         i_action         = ACT_SEARCH;
    logic [5:0]         i_position       = '0;
    logic signed [31:0] i_value          = '0;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic               o_found;
    logic [5:0]         o_found_position;
    logic [5:0]         o_length;

    int                 error_count;
    int                 pending_results;

    // Stimulus-side view of the list length, used to aim positions and count full refusals.
    int                 list_length = 0;
    int                 full_refusals = 0;
    int                 sent_count [4] = '{0, 0, 0, 0};
    logic signed [31:0] value_pool [8];
    bit                 no_idle = 1'b0;

    bounded_positional_list_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_found          (o_found),
        .o_found_position (o_found_position),
        .o_length         (o_length)
    );

    bpl_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_found          (o_found),
        .o_found_position (o_found_position),
        .o_length         (o_length),
        .o_error_count    (error_count),
        .o_pending        (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int idle_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    // Waits out the gap, presents the request and returns after the edge
    // that accepted it. With no gap, start simply stays high.
    task automatic send_request(input logic [1:0] act, input logic [5:0] pos,
                                input logic signed [31:0] val, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_action   <= act;
        i_position <= pos;
        i_value    <= val;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        sent_count[act]++;
        if (act == ACT_INSERT) begin
            if (list_length >= CAPACITY) begin
                full_refusals++;
            end else if (pos != 0 && int'(pos) <= list_length + 1) begin
                list_length++;
            end
        end else if (act == ACT_DELETE) begin
            if (pos != 0 && int'(pos) <= list_length) begin
                list_length--;
            end
        end
    endtask

    initial begin
        int                 insert_pct;
        int                 delete_pct;
        int                 search_pct;
        int                 roll;
        logic [1:0]         act;
        logic [5:0]         pos;
        logic signed [31:0] val;

        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < 8; i++) begin
            value_pool[i] = $urandom;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: bad positions, search miss and sort with nothing held.
        send_request(ACT_DELETE, 6'd1, 32'sd0, idle_gap());
        send_request(ACT_DELETE, 6'd0, 32'sd0, idle_gap());
        send_request(ACT_SEARCH, 6'd0, 32'sd0, idle_gap());
        send_request(ACT_SORT, 6'd0, 32'sd0, idle_gap());
        send_request(ACT_INSERT, 6'd0, 32'sd5, idle_gap());
        send_request(ACT_INSERT, 6'd2, 32'sd5, idle_gap());
        // Extremes of the value range, sort of a single element.
        send_request(ACT_INSERT, 6'd1, 32'sh8000_0000, idle_gap());
        send_request(ACT_SORT, 6'd0, 32'sd0, idle_gap());
        send_request(ACT_INSERT, 6'd2, 32'sh7fff_ffff, idle_gap());
        send_request(ACT_INSERT, 6'd1, 32'sd0, idle_gap());
        send_request(ACT_INSERT, 6'd4, -32'sd1, idle_gap());
        send_request(ACT_INSERT, 6'd63, 32'sd7, idle_gap());
        // Duplicate value: the search must report the lowest position.
        send_request(ACT_INSERT, 6'd2, 32'sd0, idle_gap());
        send_request(ACT_SEARCH, 6'd63, 32'sd0, idle_gap());
        send_request(ACT_SEARCH, 6'd0, -32'sd1, idle_gap());
        send_request(ACT_SEARCH, 6'd0, 32'sd12345, idle_gap());
        send_request(ACT_SORT, 6'd63, -32'sd1, idle_gap());
        send_request(ACT_SEARCH, 6'd0, 32'sh7fff_ffff, idle_gap());
        send_request(ACT_DELETE, 6'd6, 32'sd0, idle_gap());
        send_request(ACT_DELETE, 6'd5, 32'sd0, idle_gap());
        send_request(ACT_DELETE, 6'd1, 32'sd0, idle_gap());
        send_request(ACT_DELETE, 6'd63, 32'sd0, idle_gap());
        send_request(ACT_SEARCH, 6'd0, 32'sh8000_0000, idle_gap());

        // Random phases bias the mix toward filling or draining the list so
        // that the full and empty ends are both reached many times.
        insert_pct = 35;
        delete_pct = 30;
        search_pct = 25;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 2))
                    0: begin
                        insert_pct = 60; delete_pct = 15; search_pct = 17;
                    end
                    1: begin
                        insert_pct = 15; delete_pct = 60; search_pct = 17;
                    end
                    default: begin
                        insert_pct = 35; delete_pct = 30; search_pct = 25;
                    end
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) begin
                act = ACT_INSERT;
            end else if (roll < insert_pct + delete_pct) begin
                act = ACT_DELETE;
            end else if (roll < insert_pct + delete_pct + search_pct) begin
                act = ACT_SEARCH;
            end else begin
                act = ACT_SORT;
            end

            pos = 6'($urandom);
            if ($urandom_range(0, 9) < 8) begin
                if (act == ACT_INSERT) begin
                    pos = 6'($urandom_range(1, list_length + 1));
                end else if (act == ACT_DELETE && list_length > 0) begin
                    pos = 6'($urandom_range(1, list_length));
                end
            end

            if ($urandom_range(0, 9) < (act == ACT_SEARCH ? 7 : 5)) begin
                val = value_pool[$urandom_range(0, 7)];
            end else begin
                val = $urandom;
            end

            send_request(act, pos, val, idle_gap());
        end

        start <= 1'b0;
        while (pending_results != 0) @(posedge i_clk);
        repeat (LATENCY_CYCLES) @(posedge i_clk);

        $display("tb: ran %0d requests: %0d insert, %0d delete, %0d search, %0d sort",
                 sent_count[ACT_INSERT] + sent_count[ACT_DELETE] + sent_count[ACT_SEARCH]
                 + sent_count[ACT_SORT], sent_count[ACT_INSERT], sent_count[ACT_DELETE],
                 sent_count[ACT_SEARCH], sent_count[ACT_SORT]);
        $display("tb: inserts refused on a full list: %0d, mismatches: %0d",
                 full_refusals, error_count);
        if (error_count == 0 && pending_results == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
